// File: src/array_list_engine_assert.svh
// Assertion macros used by the array list engine sequencer.
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// Check that cons holds in the same cycle as ante; expects clk and rst_n in scope.
`define ALE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante; expects clk and rst_n in scope.
`define ALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/alist_pkg.sv
// Types and codes shared by the array list engine.
package alist_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_READ   = 3'd2,
    CMD_ZERO   = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_INSERT = 3'd5,
    CMD_DELETE = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_BAD_POS   = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
    logic [4:0]         found_position;
    logic [4:0]         item_count;
  } res_t;

endpackage

// File: src/alist_ifs.sv
// Valid/ready channel interfaces for commands and results.
interface alist_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] value;
  logic [4:0]         position;

  modport source (output valid, output command, output value, output position, input ready);
  modport sink   (input valid, input command, input value, input position, output ready);
endinterface

interface alist_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [4:0]         found_position;
  logic [4:0]         item_count;

  modport source (output valid, output status, output read_value, output found_position,
                  output item_count, input ready);
  modport sink   (input valid, input status, input read_value, input found_position,
                  input item_count, output ready);
endinterface

// File: src/alist_mem.sv
// Entry memory: one write port, one read port, registered read data.
module alist_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/alist_seq.sv
// Command sequencer: decodes a transaction, walks the entry memory, builds the result.
`include "array_list_engine_assert.svh"

module alist_seq #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  alist_cmd_if.sink         in_if,
  output logic              res_valid,
  input  logic              res_take,
  output alist_pkg::res_t   res,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [31:0]       mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [31:0]       mem_rdata
);

  localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

  alist_pkg::state_t state_r, state_nxt;
  alist_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [31:0]       value_r, value_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [AW-1:0]     j_r, j_nxt;
  logic [AW-1:0]     tgt_r, tgt_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_idx_r, pend_idx_nxt;
  alist_pkg::res_t   res_r, res_nxt;

  logic [CMPW-1:0] pos_x, cnt_x;
  logic            full, rd_pos_ok, ins_pos_ok;
  logic [CMPW-1:0] ins_n, del_n;

  assign pos_x      = CMPW'(in_if.position);
  assign cnt_x      = CMPW'(count_r);
  assign full       = (cnt_x >= CMPW'(DEPTH));
  assign rd_pos_ok  = (pos_x != '0) && (pos_x <= cnt_x);
  assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1));
  assign ins_n      = cnt_x - pos_x + CMPW'(1);
  assign del_n      = cnt_x - pos_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alist_pkg::S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    value_r    <= value_nxt;
    n_r        <= n_nxt;
    j_r        <= j_nxt;
    tgt_r      <= tgt_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_r      <= res_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    value_nxt    = value_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    j_nxt        = j_r;
    tgt_nxt      = tgt_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    res_nxt      = res_r;
    in_if.ready  = 1'b0;
    res_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    unique case (state_r)
      alist_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          cmd_nxt                = alist_pkg::cmd_t'(in_if.command);
          value_nxt              = in_if.value;
          pend_nxt               = 1'b0;
          res_nxt.status         = alist_pkg::STAT_OK;
          res_nxt.read_value     = '0;
          res_nxt.found_position = '0;
          res_nxt.item_count     = cnt_x[4:0];
          state_nxt              = alist_pkg::S_DONE;
          unique case (alist_pkg::cmd_t'(in_if.command))
            alist_pkg::CMD_CLEAR: begin
              count_nxt          = '0;
              res_nxt.item_count = '0;
            end
            alist_pkg::CMD_APPEND: begin
              if (full) begin
                res_nxt.status = alist_pkg::STAT_FULL;
              end else begin
                mem_we             = 1'b1;
                mem_waddr          = count_r[AW-1:0];
                mem_wdata          = in_if.value;
                count_nxt          = count_r + CW'(1);
                res_nxt.item_count = 5'(cnt_x + CMPW'(1));
              end
            end
            alist_pkg::CMD_READ: begin
              if (!rd_pos_ok) begin
                res_nxt.status = alist_pkg::STAT_BAD_POS;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(pos_x - CMPW'(1));
                state_nxt = alist_pkg::S_READ;
              end
            end
            alist_pkg::CMD_ZERO, alist_pkg::CMD_FIND: begin
              n_nxt     = count_r;
              j_nxt     = '0;
              state_nxt = alist_pkg::S_WALK;
            end
            alist_pkg::CMD_INSERT: begin
              if (full) begin
                res_nxt.status = alist_pkg::STAT_FULL;
              end else if (!ins_pos_ok) begin
                res_nxt.status = alist_pkg::STAT_BAD_POS;
              end else begin
                n_nxt     = ins_n[CW-1:0];
                j_nxt     = AW'(cnt_x - CMPW'(1));
                tgt_nxt   = AW'(pos_x - CMPW'(1));
                state_nxt = alist_pkg::S_WALK;
              end
            end
            alist_pkg::CMD_DELETE: begin
              if (!rd_pos_ok) begin
                res_nxt.status = alist_pkg::STAT_BAD_POS;
              end else begin
                n_nxt     = del_n[CW-1:0];
                j_nxt     = AW'(pos_x);
                state_nxt = alist_pkg::S_WALK;
              end
            end
            default: begin
              // unused code: no change, plain ok result
            end
          endcase
        end
      end

      alist_pkg::S_READ: begin
        res_nxt.read_value = mem_rdata;
        state_nxt          = alist_pkg::S_DONE;
      end

      alist_pkg::S_WALK: begin
        unique case (cmd_r)
          alist_pkg::CMD_ZERO: begin
            if (n_r != '0) begin
              mem_we    = 1'b1;
              mem_waddr = j_r;
              j_nxt     = j_r + AW'(1);
              n_nxt     = n_r - CW'(1);
            end else begin
              state_nxt = alist_pkg::S_DONE;
            end
          end
          alist_pkg::CMD_FIND: begin
            if (pend_r && (mem_rdata == value_r)) begin
              pend_nxt               = 1'b0;
              res_nxt.found_position = 5'(CMPW'(pend_idx_r) + CMPW'(1));
              state_nxt              = alist_pkg::S_DONE;
            end else if (n_r != '0) begin
              mem_re       = 1'b1;
              mem_raddr    = j_r;
              pend_nxt     = 1'b1;
              pend_idx_nxt = j_r;
              j_nxt        = j_r + AW'(1);
              n_nxt        = n_r - CW'(1);
            end else begin
              pend_nxt       = 1'b0;
              res_nxt.status = alist_pkg::STAT_NOT_FOUND;
              state_nxt      = alist_pkg::S_DONE;
            end
          end
          alist_pkg::CMD_INSERT: begin
            // shift right: read entry j, write it one place up next cycle
            if (pend_r) begin
              mem_we    = 1'b1;
              mem_waddr = pend_idx_r + AW'(1);
              mem_wdata = mem_rdata;
            end
            if (n_r != '0) begin
              mem_re       = 1'b1;
              mem_raddr    = j_r;
              pend_nxt     = 1'b1;
              pend_idx_nxt = j_r;
              j_nxt        = j_r - AW'(1);
              n_nxt        = n_r - CW'(1);
            end else if (pend_r) begin
              pend_nxt = 1'b0;
            end else begin
              mem_we             = 1'b1;
              mem_waddr          = tgt_r;
              mem_wdata          = value_r;
              count_nxt          = count_r + CW'(1);
              res_nxt.item_count = 5'(cnt_x + CMPW'(1));
              state_nxt          = alist_pkg::S_DONE;
            end
          end
          alist_pkg::CMD_DELETE: begin
            // shift left: read entry j, write it one place down next cycle
            if (pend_r) begin
              mem_we    = 1'b1;
              mem_waddr = pend_idx_r - AW'(1);
              mem_wdata = mem_rdata;
            end
            if (n_r != '0) begin
              mem_re       = 1'b1;
              mem_raddr    = j_r;
              pend_nxt     = 1'b1;
              pend_idx_nxt = j_r;
              j_nxt        = j_r + AW'(1);
              n_nxt        = n_r - CW'(1);
            end else if (pend_r) begin
              pend_nxt = 1'b0;
            end else begin
              count_nxt          = count_r - CW'(1);
              res_nxt.item_count = 5'(cnt_x - CMPW'(1));
              state_nxt          = alist_pkg::S_DONE;
            end
          end
          default: begin
            state_nxt = alist_pkg::S_DONE;
          end
        endcase
      end

      alist_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = alist_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = alist_pkg::S_IDLE;
      end
    endcase
  end

  assign res = res_r;

  `ALE_ASSERT_NOW(a_no_same_addr, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one entry")
  `ALE_ASSERT_NOW(a_count_bound, 1'b1, cnt_x <= CMPW'(DEPTH), "count above depth")
  `ALE_ASSERT_NEXT(a_clear_empties, in_if.valid && in_if.ready && (in_if.command == alist_pkg::CMD_CLEAR), count_r == '0, "clear left entries")
  `ALE_ASSERT_NOW(a_take_only_done, res_take, state_r == alist_pkg::S_DONE, "result taken outside done")

endmodule

// File: src/array_list_engine.sv
// Top level of the array list engine: sequencer, entry memory and result register.
//
//   channel   dir  handshake        payload
//   in_if     in   valid / ready    command[2:0], value[31:0], position[4:0]
//   out_if    out  valid / ready    status[1:0], read_value[31:0], found_position[4:0],
//                                   item_count[4:0]
//
// One transaction is worked at a time. Clear, append, a bad position, a full list and the
// unused command code go straight to the done state, a read passes through S_READ first.
// Zero and find walk the entry memory one entry per cycle; insert and delete move one entry
// per cycle through the single read and write port.
// Reset (rst_n low, synchronous) empties the list; a stalled result sits in the output
// register while the next transaction runs.
module array_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  alist_cmd_if.sink   in_if,
  alist_res_if.source out_if
);

  // Address width for the entry memory and width of the entry count.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic            res_valid;
  logic            res_take;
  alist_pkg::res_t res;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [31:0]     mem_rdata;

  logic            out_valid_r, out_valid_nxt;
  alist_pkg::res_t out_res_r, out_res_nxt;

  // Sequencer: decode, bounds checks, walk over the entries, count upkeep.
  alist_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Entry storage, registered read data.
  alist_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: take the finished result when the slot is empty or draining.
  assign res_take = res_valid && (!out_valid_r || out_if.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_if.ready) begin
      // drop the delivered transaction
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_res_r.status;
  assign out_if.read_value     = out_res_r.read_value;
  assign out_if.found_position = out_res_r.found_position;
  assign out_if.item_count     = out_res_r.item_count;

endmodule

// File: bench/alist_checker.sv
// Result checker for the array list engine: predicts each command's response and compares.
`timescale 1ns / 100ps

module alist_checker #(
  parameter int DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  alist_cmd_if  cmd_ch,
  alist_res_if  res_ch,
  output int    fail_count,
  output int    pending_results
);

  logic signed [31:0] shadow_mem [DEPTH];
  int                 shadow_len;
  alist_pkg::res_t    expected_results [$];

  // Apply one command to the shadow list and return the response it should produce.
  function automatic alist_pkg::res_t next_list_result(input logic [2:0] cmd,
                                                       input logic signed [31:0] val,
                                                       input logic [4:0] pos);
    alist_pkg::res_t r;
    int              k;
    r.status         = alist_pkg::STAT_OK;
    r.read_value     = '0;
    r.found_position = '0;
    case (cmd)
      alist_pkg::CMD_CLEAR: begin
        shadow_len = 0;
      end
      alist_pkg::CMD_APPEND: begin
        if (shadow_len >= DEPTH) begin
          r.status = alist_pkg::STAT_FULL;
        end else begin
          shadow_mem[shadow_len] = val;
          shadow_len++;
        end
      end
      alist_pkg::CMD_READ: begin
        if (pos < 1 || pos > shadow_len) begin
          r.status = alist_pkg::STAT_BAD_POS;
        end else begin
          r.read_value = shadow_mem[pos - 1];
        end
      end
      alist_pkg::CMD_ZERO: begin
        for (k = 0; k < shadow_len; k++) shadow_mem[k] = '0;
      end
      alist_pkg::CMD_FIND: begin
        r.status = alist_pkg::STAT_NOT_FOUND;
        for (k = 0; k < shadow_len; k++) begin
          if (shadow_mem[k] == val) begin
            r.status         = alist_pkg::STAT_OK;
            r.found_position = 5'(k + 1);
            break;
          end
        end
      end
      alist_pkg::CMD_INSERT: begin
        if (shadow_len >= DEPTH) begin
          r.status = alist_pkg::STAT_FULL;
        end else if (pos < 1 || pos > shadow_len + 1) begin
          r.status = alist_pkg::STAT_BAD_POS;
        end else begin
          for (k = shadow_len; k > pos - 1; k--) shadow_mem[k] = shadow_mem[k - 1];
          shadow_mem[pos - 1] = val;
          shadow_len++;
        end
      end
      alist_pkg::CMD_DELETE: begin
        if (pos < 1 || pos > shadow_len) begin
          r.status = alist_pkg::STAT_BAD_POS;
        end else begin
          for (k = pos - 1; k + 1 < shadow_len; k++) shadow_mem[k] = shadow_mem[k + 1];
          shadow_len--;
        end
      end
      default: ;
    endcase
    r.item_count = 5'(shadow_len);
    return r;
  endfunction

  initial begin
    fail_count      = 0;
    pending_results = 0;
    shadow_len      = 0;
  end

  always @(posedge clk) begin
    alist_pkg::res_t want;
    if (!rst_n) begin
      shadow_len = 0;
      expected_results.delete();
    end else begin
      // Retire the result first: it never belongs to a command accepted on the same edge.
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_ch.status);
            fail_count++;
          end
          if (res_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, res_ch.read_value);
            fail_count++;
          end
          if (res_ch.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, res_ch.found_position);
            fail_count++;
          end
          if (res_ch.item_count !== want.item_count) begin
            $error("item_count: expected %0d, got %0d", want.item_count, res_ch.item_count);
            fail_count++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_results.push_back(next_list_result(cmd_ch.command, cmd_ch.value,
                                                     cmd_ch.position));
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// File: bench/tb_array_list_engine.sv
// Testbench top for the array list engine: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module tb_array_list_engine;

  localparam int         LIST_DEPTH       = 16;
  localparam int         RANDOM_PER_PHASE = 400;
  localparam logic [2:0] CMD_UNUSED       = 3'd7;

  logic               clk;
  logic               rst_n;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 fail_count;
  int                 pending_results;
  logic [4:0]         len_hint;
  logic signed [31:0] value_pool [8];

  alist_cmd_if cmd_ch ();
  alist_res_if res_ch ();

  array_list_engine #(
    .DEPTH (LIST_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_ch),
    .out_if (res_ch)
  );

  alist_checker #(
    .DEPTH (LIST_DEPTH)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_ch          (cmd_ch),
    .res_ch          (res_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: drop ready at random on each falling edge, per the current idle rate.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Track the list length from the last accepted result; it steers positions
  // toward the valid range so reads, inserts and deletes mostly do real work.
  always @(posedge clk) begin
    if (!rst_n) begin
      len_hint <= '0;
    end else if (res_ch.valid && res_ch.ready) begin
      len_hint <= res_ch.item_count;
    end
  end

  // Present one command at a falling edge and hold it until it is accepted.
  // Leaves the caller at the falling edge after acceptance, valid still high.
  task automatic send_command(input logic [2:0] cmd, input logic signed [31:0] val,
                              input logic [4:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid    = 1'b1;
    cmd_ch.command  = cmd;
    cmd_ch.value    = val;
    cmd_ch.position = pos;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every outstanding response has been retired.
  task automatic drain_results();
    cmd_ch.valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Random traffic in alternating grow and shrink stretches so the list swings
  // between empty and full, with values drawn partly from recently stored data.
  task automatic run_random(input int n_items);
    int                 block_left;
    bit                 grow;
    int                 pick;
    logic [2:0]         cmd;
    logic signed [31:0] val;
    logic [4:0]         pos;
    grow       = 1'b1;
    block_left = $urandom_range(30, 90);
    for (int i = 0; i < n_items; i++) begin
      if (block_left == 0) begin
        grow       = ~grow;
        block_left = $urandom_range(30, 90);
      end
      block_left--;

      // Pick the command; grow stretches favor append and insert, shrink favors delete.
      pick = $urandom_range(99);
      if (grow) begin
        if      (pick < 2)  cmd = alist_pkg::CMD_CLEAR;
        else if (pick < 32) cmd = alist_pkg::CMD_APPEND;
        else if (pick < 54) cmd = alist_pkg::CMD_INSERT;
        else if (pick < 68) cmd = alist_pkg::CMD_READ;
        else if (pick < 82) cmd = alist_pkg::CMD_FIND;
        else if (pick < 85) cmd = alist_pkg::CMD_ZERO;
        else if (pick < 98) cmd = alist_pkg::CMD_DELETE;
        else                cmd = CMD_UNUSED;
      end else begin
        if      (pick < 3)  cmd = alist_pkg::CMD_CLEAR;
        else if (pick < 13) cmd = alist_pkg::CMD_APPEND;
        else if (pick < 21) cmd = alist_pkg::CMD_INSERT;
        else if (pick < 36) cmd = alist_pkg::CMD_READ;
        else if (pick < 51) cmd = alist_pkg::CMD_FIND;
        else if (pick < 55) cmd = alist_pkg::CMD_ZERO;
        else if (pick < 98) cmd = alist_pkg::CMD_DELETE;
        else                cmd = CMD_UNUSED;
      end

      // Value: extremes, recently stored values, or fully random bits.
      case ($urandom_range(9))
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7FFF_FFFF;
        2:       val = '0;
        3:       val = -32'sd1;
        4, 5, 6: val = value_pool[$urandom_range(7)];
        default: val = $urandom;
      endcase

      // Position: mostly inside the list, sometimes at or past its edges, sometimes any code.
      case ($urandom_range(9))
        0:       pos = 5'($urandom_range(31));
        1:       pos = '0;
        2:       pos = len_hint + 5'd1 + 5'($urandom_range(1));
        default: pos = 5'($urandom_range(1, len_hint + 1));
      endcase

      if (cmd == alist_pkg::CMD_APPEND || cmd == alist_pkg::CMD_INSERT) begin
        value_pool[$urandom_range(7)] = val;
      end
      send_command(cmd, val, pos);
    end
  endtask

  initial begin
    cmd_ch.valid    = 1'b0;
    cmd_ch.command  = '0;
    cmd_ch.value    = '0;
    cmd_ch.position = '0;
    rst_n           = 1'b0;
    send_idle_pct   = 16;
    recv_idle_pct   = 52;
    for (int k = 0; k < 8; k++) value_pool[k] = $urandom_range(15);

    // Hold reset low, then release it on a falling edge.
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty-list errors, extremes of value and position, every command.
    send_command(alist_pkg::CMD_READ,   32'sd0,         5'd1);   // read on empty list
    send_command(alist_pkg::CMD_DELETE, 32'sd0,         5'd1);   // delete on empty list
    send_command(alist_pkg::CMD_FIND,   32'sd0,         5'd0);   // find on empty list
    send_command(alist_pkg::CMD_INSERT, 32'sd9,         5'd0);   // insert at position zero
    send_command(alist_pkg::CMD_INSERT, 32'sd9,         5'd2);   // insert past count + 1
    send_command(alist_pkg::CMD_INSERT, 32'sh8000_0000, 5'd1);   // insert into empty list
    send_command(alist_pkg::CMD_APPEND, 32'sh7FFF_FFFF, 5'd31);
    send_command(alist_pkg::CMD_APPEND, -32'sd1,        5'd0);
    send_command(alist_pkg::CMD_READ,   32'sd0,         5'd3);   // last entry
    send_command(alist_pkg::CMD_READ,   32'sd0,         5'd4);   // one past the end
    send_command(alist_pkg::CMD_READ,   32'sd0,         5'd0);
    send_command(alist_pkg::CMD_FIND,   -32'sd1,        5'd0);
    send_command(alist_pkg::CMD_FIND,   32'sd12345,     5'd0);   // no match
    send_command(alist_pkg::CMD_INSERT, 32'sd7,         5'd4);   // insert at count + 1
    send_command(alist_pkg::CMD_INSERT, 32'sh5555_5555, 5'd2);   // insert in the middle
    send_command(alist_pkg::CMD_DELETE, 32'sd0,         5'd1);   // delete the head
    send_command(alist_pkg::CMD_DELETE, 32'sd0,         5'd31);  // position far out of range
    send_command(alist_pkg::CMD_DELETE, 32'sd0,         5'd4);   // delete the tail
    send_command(alist_pkg::CMD_ZERO,   32'shAAAA_AAAA, 5'd16);
    send_command(alist_pkg::CMD_FIND,   32'sd0,         5'd0);
    send_command(alist_pkg::CMD_READ,   32'sd0,         5'd2);
    send_command(CMD_UNUSED,            32'shFFFF_FFFF, 5'd31);  // unused code: no change
    send_command(alist_pkg::CMD_CLEAR,  32'sd0,         5'd0);
    send_command(alist_pkg::CMD_READ,   32'sd0,         5'd1);   // read after clear

    // Pause the sender until every response is back before random traffic starts.
    drain_results();

    // Phase 1: sender lightly idle, receiver heavily stalled.
    run_random(RANDOM_PER_PHASE);
    drain_results();

    // Phase 2: swap the idle rates.
    send_idle_pct = 52;
    recv_idle_pct = 16;
    run_random(RANDOM_PER_PHASE);
    drain_results();

    // Phase 3: back-to-back on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);
    drain_results();

    // Let any stray response surface before the verdict.
    repeat (LIST_DEPTH + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: array_list_engine.f
+incdir+src
src/alist_pkg.sv
src/alist_ifs.sv
src/alist_mem.sv
src/alist_seq.sv
src/array_list_engine.sv
bench/alist_checker.sv
bench/tb_array_list_engine.sv
